/* sv/awf_pkg.sv */
// Shared constants, codes and types of the adaptive Wiener image filter.
// No dependencies; awf_div, awf_store, the filter and its testbench import it.
package awf_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_WINDOW = 15;

  localparam int COORD_W = 8;
  localparam int DIM_W   = 9;
  localparam int WIN_W   = 4;
  localparam int PIX_W   = 8;
  localparam int NOISE_W = 24;
  localparam int ADDR_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);

  localparam int S_W    = 16;
  localparam int Q_W    = 24;
  localparam int MEAN_W = 16;
  localparam int VAR_W  = 24;
  localparam int TOT_W  = 40;
  localparam int DABS_W = 17;
  localparam int RES_W  = 19;

  localparam int DVD_W = 41;
  localparam int DVS_W = 24;
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 17;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_FILTER   = 2'd1,
    OP_ESTIMATE = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic {
    KIND_FILTER   = 1'b0,
    KIND_ESTIMATE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_WINDOW = 2'd2,
    CFG_NOISE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SETUP, ST_SWEEP, ST_DRAIN,
    ST_MEAN_GO, ST_MEAN_W, ST_EX2_GO, ST_EX2_W,
    ST_MSQ, ST_VAR, ST_GAIN_PREP, ST_NUMD,
    ST_GAIN_GO, ST_GAIN_W, ST_ACC, ST_HW,
    ST_TOT_GO, ST_TOT_W, ST_FIN
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* sv/awf_in_if.sv */
// Request channel of the adaptive Wiener image filter.
// Standalone; valid/ready handshake with the request fields.
interface awf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] row;
  logic [7:0] col;
  logic [7:0] pixel_value;

  modport source (output valid, operation, row, col, pixel_value, input ready);
  modport sink   (input valid, operation, row, col, pixel_value, output ready);
endinterface

/* sv/awf_out_if.sv */
// Result channel of the adaptive Wiener image filter.
// Standalone; valid/ready handshake with the result fields.
interface awf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  filtered_pixel;
  logic [23:0] noise_estimate;
  logic        result_kind;

  modport source (output valid, filtered_pixel, noise_estimate, result_kind, input ready);
  modport sink   (input valid, filtered_pixel, noise_estimate, result_kind, output ready);
endinterface

/* sv/awf_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on awf_pkg for widths and the request/response structs.
module awf_div import awf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   shifted;
  logic             ge;
  logic [DVS_W:0]   diff;

  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

/* sv/awf_store.sv */
// Image pixel memory: one write port, one registered read port.
// Depends on awf_pkg for address and pixel widths.
module awf_store import awf_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [PIX_W-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [PIX_W-1:0]  rdata
);

  logic [PIX_W-1:0] mem [MAX_WIDTH*MAX_HEIGHT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/adaptive_wiener_image_filter.sv */
// Adaptive Wiener (local statistics) filter over a stored 8-bit image.
// Depends on awf_pkg, awf_in_if, awf_out_if, awf_div and awf_store.
//
// Usage:
//  - in_ch carries requests: write pixel, filter pixel, estimate noise.
//    A beat is taken only while the sequencer is idle.
//  - A write returns nothing.
//  - A filter beat reads the clipped window from the image memory, one
//    pixel a cycle, then runs two divisions for mean and mean square,
//    one multiply for the squared mean, one multiply and one division for
//    the gain. The sequencer is idle again, ready for the next request,
//    in the same cycle that the result beat becomes valid. The window
//    holds at most 225 pixels (15x15). Each division holds the sequencer
//    in its start and wait states until the divider is done. With
//    variance and noise both zero the gain division is skipped.
//    A filter position outside the image returns nothing.
//  - An estimate beat runs the same statistics for every pixel of the
//    image and divides the summed variance by width*height. The result
//    is kept as the noise used while cfg noise_variance is zero.
//  - Results land in an output register; the next request is taken while
//    a result waits. A finished result waits in the sequencer if the
//    register still holds an untaken beat (out_ch.ready low).
//  - cfg_we/cfg_index/cfg_data write registers; only while idle.
//  - Synchronous reset: registers to defaults, estimate to zero. The
//    image memory is not cleared; unwritten pixels read as garbage.
module adaptive_wiener_image_filter import awf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  awf_in_if.sink             in_ch,
  awf_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [NOISE_W-1:0] cfg_data
);

  // configuration
  logic [DIM_W-1:0]   cfg_w_r, cfg_h_r;
  logic [WIN_W-1:0]   cfg_win_r;
  logic [NOISE_W-1:0] cfg_noise_r;

  // effective geometry
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [WIN_W-1:0] n_sat, n_eff, half;
  logic [7:0]       nn;

  // sequencer
  state_t state_r, state_nxt;
  kind_t  kind_r;

  logic [COORD_W-1:0] cr_r, cc_r;
  logic [COORD_W-1:0] i_r, j_r, r1_r, c0_r, c1_r;
  logic [DIM_W-1:0]   r0_w, c0_w, r1_w, c1_w;
  logic               rd_vld_r, rd_ctr_r;
  logic               sweep_last, last_col, last_row;

  // datapath
  logic [S_W-1:0]     s_r;
  logic [Q_W-1:0]     q_r;
  logic [PIX_W-1:0]   ctr_r;
  logic [MEAN_W-1:0]  mean_r;
  logic [VAR_W-1:0]   ex2_r, var_r, num_r, den_r;
  logic [TOT_W-1:0]   tot_r;
  logic [DVD_W-1:0]   prod_r;
  logic [DABS_W-1:0]  dabs_r;
  logic               dneg_r;
  logic signed [RES_W-1:0] res_r;
  logic [NOISE_W-1:0] est_r;

  logic [VAR_W-1:0]   msq, noise;
  logic [17:0]        dsg;
  logic [DABS_W-1:0]  qmag;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [DVD_W-1:0]   product;
  logic [PIX_W-1:0]   pix_out;

  // memory
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [PIX_W-1:0]  mem_rdata;

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  // output register
  logic               out_vld_r;
  logic [PIX_W-1:0]   out_pix_r;
  logic [NOISE_W-1:0] out_noise_r;
  logic               out_kind_r;
  logic               out_load;

  logic in_acc;
  op_t  in_op;

  awf_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  awf_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_ch.pixel_value),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r     <= DIM_W'(256);
      cfg_h_r     <= DIM_W'(256);
      cfg_win_r   <= WIN_W'(3);
      cfg_noise_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  cfg_w_r     <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT: cfg_h_r     <= cfg_data[DIM_W-1:0];
        CFG_WINDOW: cfg_win_r   <= cfg_data[WIN_W-1:0];
        CFG_NOISE:  cfg_noise_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero dimension means one; oversize clamps
  assign w_eff = (cfg_w_r == '0) ? DIM_W'(1) :
                 (cfg_w_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : cfg_w_r;
  assign h_eff = (cfg_h_r == '0) ? DIM_W'(1) :
                 (cfg_h_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : cfg_h_r;

  // even window drops to the next odd size, zero becomes one
  assign n_sat = (cfg_win_r > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : cfg_win_r;
  assign n_eff = n_sat[0] ? n_sat : ((n_sat == '0) ? WIN_W'(1) : n_sat - 1'b1);
  assign half  = (n_eff - 1'b1) >> 1;
  assign nn    = 8'({4'b0, n_eff} * {4'b0, n_eff});

  // window bounds around the current center, clipped to the image
  assign r0_w = ({1'b0, cr_r} >= DIM_W'(half)) ? {1'b0, cr_r} - DIM_W'(half) : '0;
  assign c0_w = ({1'b0, cc_r} >= DIM_W'(half)) ? {1'b0, cc_r} - DIM_W'(half) : '0;
  assign r1_w = ({1'b0, cr_r} + DIM_W'(half) < h_eff) ? {1'b0, cr_r} + DIM_W'(half)
                                                        : h_eff - 1'b1;
  assign c1_w = ({1'b0, cc_r} + DIM_W'(half) < w_eff) ? {1'b0, cc_r} + DIM_W'(half)
                                                        : w_eff - 1'b1;

  assign sweep_last = (j_r == c1_r) && (i_r == r1_r);
  assign last_col   = ({1'b0, cc_r} == w_eff - 1'b1);
  assign last_row   = ({1'b0, cr_r} == h_eff - 1'b1);

  assign in_op  = op_t'(in_ch.operation);
  assign in_acc = in_ch.valid && in_ch.ready;

  // ---------------- arithmetic helpers ----------------
  assign msq   = prod_r[31:8];
  assign noise = (cfg_noise_r != '0) ? cfg_noise_r : est_r;
  assign dsg   = {2'b0, ctr_r, 8'b0} - {2'b0, mean_r};
  assign qmag  = div_rsp.quotient[DABS_W-1:0];

  // shared multiplier, operands picked by state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MSQ: begin
        mul_a = MUL_A_W'(mean_r);
        mul_b = MUL_B_W'(mean_r);
      end
      ST_NUMD: begin
        mul_a = num_r;
        mul_b = dabs_r;
      end
      ST_HW: begin
        mul_a = MUL_A_W'(h_eff);
        mul_b = MUL_B_W'(w_eff);
      end
      default: ;
    endcase
  end
  assign product = DVD_W'(mul_a) * DVD_W'(mul_b);

  // saturate the Q8 result to a gray level
  assign pix_out = res_r[RES_W-1] ? '0 :
                   (res_r[RES_W-2:16] != '0) ? '1 : res_r[15:8];

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_FILTER) begin
            if (({1'b0, in_ch.row} < h_eff) && ({1'b0, in_ch.col} < w_eff)) begin
              state_nxt = ST_SETUP;
            end
          end else if (in_op == OP_ESTIMATE) begin
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP:     state_nxt = ST_SWEEP;
      ST_SWEEP:     if (sweep_last) state_nxt = ST_DRAIN;
      ST_DRAIN:     state_nxt = ST_MEAN_GO;
      ST_MEAN_GO:   state_nxt = ST_MEAN_W;
      ST_MEAN_W:    if (div_rsp.done) state_nxt = ST_EX2_GO;
      ST_EX2_GO:    state_nxt = ST_EX2_W;
      ST_EX2_W:     if (div_rsp.done) state_nxt = ST_MSQ;
      ST_MSQ:       state_nxt = ST_VAR;
      ST_VAR:       state_nxt = (kind_r == KIND_ESTIMATE) ? ST_ACC : ST_GAIN_PREP;
      ST_GAIN_PREP: begin
        if ((var_r > noise ? var_r : noise) == '0) state_nxt = ST_FIN;
        else state_nxt = ST_NUMD;
      end
      ST_NUMD:      state_nxt = ST_GAIN_GO;
      ST_GAIN_GO:   state_nxt = ST_GAIN_W;
      ST_GAIN_W:    if (div_rsp.done) state_nxt = ST_FIN;
      ST_ACC:       state_nxt = (last_col && last_row) ? ST_HW : ST_SETUP;
      ST_HW:        state_nxt = ST_TOT_GO;
      ST_TOT_GO:    state_nxt = ST_TOT_W;
      ST_TOT_W:     if (div_rsp.done) state_nxt = ST_FIN;
      ST_FIN:       if (out_load) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- outputs of the sequencer ----------------
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_r)
      ST_MEAN_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'({s_r, 8'b0});
        div_req.divisor  = DVS_W'(nn);
      end
      ST_EX2_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'({q_r, 8'b0});
        div_req.divisor  = DVS_W'(nn);
      end
      ST_GAIN_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_r;
        div_req.divisor  = den_r;
      end
      ST_TOT_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(tot_r);
        div_req.divisor  = DVS_W'(prod_r[17:0]);
      end
      default: ;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign mem_we      = in_acc && (in_op == OP_WRITE) &&
                       ({1'b0, in_ch.row} < DIM_W'(MAX_HEIGHT)) &&
                       ({1'b0, in_ch.col} < DIM_W'(MAX_WIDTH));
  assign mem_waddr   = ADDR_W'(in_ch.row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_ch.col);
  assign mem_raddr   = ADDR_W'(i_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(j_r);
  assign out_load    = (state_r == ST_FIN) && (!out_vld_r || out_ch.ready);

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      est_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == ST_SWEEP);
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (state_r == ST_TOT_W && div_rsp.done) begin
        est_r <= (div_rsp.quotient > DVD_W'(24'hFFFFFF)) ? '1
                                                         : div_rsp.quotient[NOISE_W-1:0];
      end
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    rd_ctr_r <= (i_r == cr_r) && (j_r == cc_r);
    if (rd_vld_r) begin
      s_r <= s_r + S_W'(mem_rdata);
      q_r <= q_r + Q_W'(mem_rdata * mem_rdata);
      if (rd_ctr_r) ctr_r <= mem_rdata;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_ESTIMATE) begin
            kind_r <= KIND_ESTIMATE;
            cr_r   <= '0;
            cc_r   <= '0;
            tot_r  <= '0;
          end else begin
            kind_r <= KIND_FILTER;
            cr_r   <= in_ch.row;
            cc_r   <= in_ch.col;
          end
        end
      end
      ST_SETUP: begin
        i_r  <= r0_w[COORD_W-1:0];
        j_r  <= c0_w[COORD_W-1:0];
        c0_r <= c0_w[COORD_W-1:0];
        c1_r <= c1_w[COORD_W-1:0];
        r1_r <= r1_w[COORD_W-1:0];
        s_r  <= '0;
        q_r  <= '0;
      end
      ST_SWEEP: begin
        if (j_r == c1_r) begin
          j_r <= c0_r;
          if (i_r != r1_r) i_r <= i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      ST_MEAN_W: if (div_rsp.done) mean_r <= div_rsp.quotient[MEAN_W-1:0];
      ST_EX2_W:  if (div_rsp.done) ex2_r  <= div_rsp.quotient[VAR_W-1:0];
      ST_MSQ:    prod_r <= product;
      ST_VAR:    var_r  <= (ex2_r > msq) ? ex2_r - msq : '0;
      ST_GAIN_PREP: begin
        num_r  <= (var_r > noise) ? var_r - noise : '0;
        den_r  <= (var_r > noise) ? var_r : noise;
        dneg_r <= dsg[17];
        dabs_r <= dsg[17] ? DABS_W'(-dsg) : dsg[DABS_W-1:0];
        res_r  <= RES_W'({3'b0, mean_r});
      end
      ST_NUMD:   prod_r <= product;
      ST_GAIN_W: begin
        if (div_rsp.done) begin
          res_r <= dneg_r ? RES_W'({3'b0, mean_r}) - RES_W'({2'b0, qmag})
                          : RES_W'({3'b0, mean_r}) + RES_W'({2'b0, qmag});
        end
      end
      ST_ACC: begin
        tot_r <= tot_r + TOT_W'(var_r);
        if (last_col) begin
          cc_r <= '0;
          if (!last_row) cr_r <= cr_r + 1'b1;
        end else begin
          cc_r <= cc_r + 1'b1;
        end
      end
      ST_HW: prod_r <= product;
      default: ;
    endcase
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r <= kind_r;
      if (kind_r == KIND_ESTIMATE) begin
        out_pix_r   <= '0;
        out_noise_r <= est_r;
      end else begin
        out_pix_r   <= pix_out;
        out_noise_r <= '0;
      end
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.filtered_pixel = out_pix_r;
  assign out_ch.noise_estimate = out_noise_r;
  assign out_ch.result_kind    = out_kind_r;

`ifndef ASSERT_OFF
  // divider finishes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_MEAN_W || state_r == ST_EX2_W ||
                      state_r == ST_GAIN_W || state_r == ST_TOT_W))
    else $error("divider done outside a wait state");

  // memory read data is consumed only right after a sweep cycle
  a_rd_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r) == ST_SWEEP)
    else $error("window read valid without sweep");

  // a result beat appears only from the finish state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r) == ST_FIN)
    else $error("result beat not from finish state");
`endif

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for adaptive_wiener_image_filter.
// Depends on awf_pkg, awf_in_if, awf_out_if and the filter RTL; predicts
// every result from its own image copy and compares beat by beat.
module testbench;
  import awf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 200000;   // cycles with no beat on any channel
  localparam int LONG_HOLD   = 3000;     // receiver hold-off while sender pushes
  localparam int SETTLE      = 40;       // cycles before a register write
  localparam int RAND_ITEMS  = 900;

  typedef struct {
    logic [7:0]  pix;
    logic [23:0] est;
    kind_t       kind;
  } wiener_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [NOISE_W-1:0] cfg_data = '0;

  awf_in_if  in_ch();
  awf_out_if out_ch();

  adaptive_wiener_image_filter dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_NONE;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.pixel_value = '0;
    out_ch.ready = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow state: image copy, which entries hold a defined value, settings,
  // and the estimate the block keeps.
  // ---------------------------------------------------------------------------
  logic [7:0]  img_copy [MAX_WIDTH*MAX_HEIGHT];
  bit          pix_known [MAX_WIDTH*MAX_HEIGHT];
  logic [8:0]  sh_width  = 9'd256;
  logic [8:0]  sh_height = 9'd256;
  logic [3:0]  sh_window = 4'd3;
  logic [23:0] sh_noise  = '0;
  logic [23:0] sh_estimate = '0;

  wiener_result_t pending_results[$];

  int errors = 0;
  int n_writes = 0, n_filters = 0, n_estimates = 0, n_idle_ops = 0, n_outside = 0;
  int n_checked = 0, n_sent = 0, n_cfg = 0;
  int burst_left = 0;
  bit sender_gaps = 1'b1;
  int hold_requests = 0;

  function automatic int eff_width();
    if (sh_width == 0) return 1;
    return (sh_width > MAX_WIDTH) ? MAX_WIDTH : int'(sh_width);
  endfunction

  function automatic int eff_height();
    if (sh_height == 0) return 1;
    return (sh_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(sh_height);
  endfunction

  function automatic int eff_window();
    int n = sh_window;
    if (n > MAX_WINDOW) n = MAX_WINDOW;
    if (n % 2 == 0) n = (n == 0) ? 1 : n - 1;
    return n;
  endfunction

  // Clipped window bounds around (r,c).
  function automatic void window_bounds(input int r, c, output int r0, r1, c0, c1);
    int half = (eff_window() - 1) / 2;
    r0 = (r >= half) ? r - half : 0;
    c0 = (c >= half) ? c - half : 0;
    r1 = (r + half < eff_height()) ? r + half : eff_height() - 1;
    c1 = (c + half < eff_width()) ? c + half : eff_width() - 1;
  endfunction

  function automatic bit window_known(input int r, c);
    int r0, r1, c0, c1;
    window_bounds(r, c, r0, r1, c0, c1);
    for (int i = r0; i <= r1; i++)
      for (int j = c0; j <= c1; j++)
        if (!pix_known[i*MAX_WIDTH + j]) return 1'b0;
    return 1'b1;
  endfunction

  // Q8 local mean and variance, sums divided by the full n*n.
  function automatic void local_mean_var(input int r, c, output longint mean_q, var_q);
    int r0, r1, c0, c1;
    longint s = 0, q = 0, nn, ex2, msq, p;
    nn = eff_window() * eff_window();
    window_bounds(r, c, r0, r1, c0, c1);
    for (int i = r0; i <= r1; i++)
      for (int j = c0; j <= c1; j++) begin
        p = img_copy[i*MAX_WIDTH + j];
        s += p;
        q += p * p;
      end
    mean_q = (s * 256) / nn;
    ex2 = (q * 256) / nn;
    msq = (mean_q * mean_q) / 256;
    var_q = (ex2 > msq) ? ex2 - msq : 0;
  endfunction

  // Updates the shadow state for one accepted request and queues its result.
  function automatic void predict_request(input op_t op, input logic [7:0] r, c, pv);
    wiener_result_t res;
    longint mean_q, var_q, noise, num, den, acc, d, o, total;
    case (op)
      OP_WRITE: begin
        img_copy[r*MAX_WIDTH + c] = pv;
        pix_known[r*MAX_WIDTH + c] = 1'b1;
      end
      OP_FILTER: begin
        if (r >= eff_height() || c >= eff_width()) return;
        local_mean_var(r, c, mean_q, var_q);
        noise = (sh_noise != 0) ? sh_noise : sh_estimate;
        num = (var_q > noise) ? var_q - noise : 0;
        den = (var_q > noise) ? var_q : noise;
        d = longint'(img_copy[r*MAX_WIDTH + c]) * 256 - mean_q;
        acc = mean_q;
        if (den != 0) acc += (num * d) / den;   // signed division truncates to zero
        o = (acc < 0) ? 0 : acc / 256;
        if (o > 255) o = 255;
        res.pix = o[7:0];
        res.est = '0;
        res.kind = KIND_FILTER;
        pending_results.push_back(res);
      end
      OP_ESTIMATE: begin
        total = 0;
        for (int i = 0; i < eff_height(); i++)
          for (int j = 0; j < eff_width(); j++) begin
            local_mean_var(i, j, mean_q, var_q);
            total += var_q;
          end
        total = total / (eff_height() * eff_width());
        if (total > 64'hFF_FFFF) total = 64'hFF_FFFF;
        sh_estimate = total[23:0];
        res.pix = '0;
        res.est = total[23:0];
        res.kind = KIND_ESTIMATE;
        pending_results.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one request beat, with bursts and random gaps between them.
  // ---------------------------------------------------------------------------
  task automatic send_request(input op_t op, input logic [7:0] r, c, pv);
    int gap;
    if (burst_left == 0) begin
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.row <= r;
    in_ch.col <= c;
    in_ch.pixel_value <= pv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_request(op, r, c, pv);
    burst_left--;
    n_sent++;
    case (op)
      OP_WRITE:    n_writes++;
      OP_FILTER:   if (r < eff_height() && c < eff_width()) n_filters++; else n_outside++;
      OP_ESTIMATE: n_estimates++;
      default:     n_idle_ops++;
    endcase
  endtask

  // Drops valid and waits until every queued result has come back.
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register write, only with the block idle.
  task automatic write_setting(input cfg_idx_t idx, input logic [NOISE_W-1:0] value);
    wait_results_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WIDTH:  sh_width  = value[8:0];
      CFG_HEIGHT: sh_height = value[8:0];
      CFG_WINDOW: sh_window = value[3:0];
      CFG_NOISE:  sh_noise  = value[23:0];
    endcase
    n_cfg++;
  endtask

  // Writes every pixel of the active image; style picks the content.
  task automatic fill_image(input int style);
    logic [7:0] pv;
    for (int r = 0; r < eff_height(); r++)
      for (int c = 0; c < eff_width(); c++) begin
        case (style)
          1: pv = 8'd0;
          2: pv = 8'd255;
          3: pv = ((r + c) % 2) ? 8'd255 : 8'd0;
          default: pv = $urandom_range(0, 255);
        endcase
        send_request(OP_WRITE, r, c, pv);
      end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern is redrawn whenever its mode counter runs out; a
  // hold-off request forces a long stretch of ready low.
  // ---------------------------------------------------------------------------
  int rx_mode = 0, rx_mode_cnt = 0, rx_hold_left = 0, rx_holds_seen = 0;

  always @(posedge clk) begin
    if (hold_requests != rx_holds_seen) begin
      rx_holds_seen <= hold_requests;
      rx_hold_left <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_mode_cnt == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_mode_cnt <= $urandom_range(100, 600);
      end else begin
        rx_mode_cnt <= rx_mode_cnt - 1;
      end
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= ($urandom_range(0, 9) < 3);
        default: out_ch.ready <= 1'b0;
      endcase
    end
  end

  // Result checker: every result beat against the oldest expectation.
  always @(posedge clk) begin
    wiener_result_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: kind %0d pixel %0d estimate %0d",
               out_ch.result_kind, out_ch.filtered_pixel, out_ch.noise_estimate);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        n_checked++;
        if (out_ch.result_kind !== exp_res.kind) begin
          $error("result_kind: expected %0d, got %0d", exp_res.kind, out_ch.result_kind);
          errors++;
        end
        if (out_ch.filtered_pixel !== exp_res.pix) begin
          $error("filtered_pixel: expected %0d, got %0d", exp_res.pix, out_ch.filtered_pixel);
          errors++;
        end
        if (out_ch.noise_estimate !== exp_res.est) begin
          $error("noise_estimate: expected %0d, got %0d", exp_res.est, out_ch.noise_estimate);
          errors++;
        end
      end
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings (256x256, window 3, estimate noise still zero): corners of
  // the store, pixel extremes, an unused opcode.
  task automatic test_reset_defaults();
    send_request(OP_WRITE, 0, 0, 8'd255);
    send_request(OP_WRITE, 0, 1, 8'd0);
    send_request(OP_WRITE, 1, 0, 8'd0);
    send_request(OP_WRITE, 1, 1, 8'd255);
    send_request(OP_FILTER, 0, 0, 8'd0);
    send_request(OP_WRITE, 255, 255, 8'd170);
    send_request(OP_WRITE, 254, 254, 8'd85);
    send_request(OP_WRITE, 254, 255, 8'd1);
    send_request(OP_WRITE, 255, 254, 8'd254);
    send_request(OP_NONE, 8'd255, 8'd255, 8'd255);
    send_request(OP_FILTER, 255, 255, 8'd0);
  endtask

  // Zero dimensions and window, 0/0 gain, positions outside the image,
  // even and largest windows, largest noise.
  task automatic test_degenerate_settings();
    write_setting(CFG_WIDTH, 0);
    write_setting(CFG_HEIGHT, 0);
    write_setting(CFG_WINDOW, 0);
    write_setting(CFG_NOISE, 0);
    send_request(OP_FILTER, 0, 0, 8'd0);      // flat 1x1: var and noise both zero
    send_request(OP_FILTER, 0, 1, 8'd0);      // outside: no result
    send_request(OP_FILTER, 1, 0, 8'd0);
    send_request(OP_ESTIMATE, 0, 0, 8'd0);
    write_setting(CFG_WIDTH, 3);
    write_setting(CFG_HEIGHT, 2);
    write_setting(CFG_WINDOW, 14);            // even, runs as 13
    fill_image(3);
    send_request(OP_ESTIMATE, 0, 0, 8'd0);
    send_request(OP_FILTER, 1, 2, 8'd0);
    send_request(OP_FILTER, 2, 0, 8'd0);
    write_setting(CFG_NOISE, 24'd16646400);
    send_request(OP_FILTER, 0, 0, 8'd0);
    write_setting(CFG_WINDOW, 15);
    send_request(OP_FILTER, 0, 1, 8'd0);
    write_setting(CFG_NOISE, 0);              // back to the stored estimate
    send_request(OP_FILTER, 1, 1, 8'd0);
  endtask

  // Widest and tallest images, through saturation of oversize values.
  task automatic test_extreme_dimensions();
    write_setting(CFG_WIDTH, 9'd511);
    write_setting(CFG_HEIGHT, 1);
    write_setting(CFG_WINDOW, 15);
    fill_image(0);
    for (int i = 0; i < 20; i++) send_request(OP_FILTER, 0, $urandom_range(0, 255), 0);
    send_request(OP_FILTER, 0, 255, 0);
    write_setting(CFG_WIDTH, 1);
    write_setting(CFG_HEIGHT, 9'd300);
    write_setting(CFG_NOISE, $urandom_range(1, 4000));
    fill_image(2);
    for (int i = 0; i < 20; i++) send_request(OP_FILTER, $urandom_range(0, 255), 0, 0);
    send_request(OP_FILTER, 255, 1, 0);       // outside the one column
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // block backs up and stalls its input; then the sender waits for a drain.
  task automatic test_backpressure();
    write_setting(CFG_WIDTH, 6);
    write_setting(CFG_HEIGHT, 5);
    write_setting(CFG_WINDOW, 5);
    fill_image(0);
    wait_results_drained();
    sender_gaps = 1'b0;
    hold_requests++;
    for (int i = 0; i < 30; i++)
      send_request(OP_FILTER, $urandom_range(0, 4), $urandom_range(0, 5), 0);
    send_request(OP_ESTIMATE, 0, 0, 0);
    wait_results_drained();
    sender_gaps = 1'b1;
  endtask

  // Random phases: new settings, a filled image, then a mix of requests.
  task automatic test_random_traffic();
    int w, h, sel, r, c, budget;
    logic [23:0] nv;
    budget = n_sent + RAND_ITEMS;
    while (n_sent < budget) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        w = 9'd256; h = $urandom_range(1, 2);
      end else if (sel == 1) begin
        w = $urandom_range(1, 2); h = 256;
      end else begin
        w = $urandom_range(1, 10); h = $urandom_range(1, 10);
      end
      write_setting(CFG_WIDTH, w);
      write_setting(CFG_HEIGHT, h);
      write_setting(CFG_WINDOW, $urandom_range(0, 15));
      case ($urandom_range(0, 4))
        0, 1: nv = 0;
        2:    nv = 24'd16646400;
        3:    nv = $urandom_range(1, 65535);
        default: nv = $urandom_range(1, 16646400);
      endcase
      write_setting(CFG_NOISE, nv);
      sender_gaps = ($urandom_range(0, 3) != 0);
      fill_image($urandom_range(0, 6));       // random content most of the time
      for (int k = 0; k < 60; k++) begin
        sel = $urandom_range(0, 99);
        r = $urandom_range(0, eff_height() - 1);
        c = $urandom_range(0, eff_width() - 1);
        if (sel < 50) begin
          send_request(OP_FILTER, r, c, 0);
        end else if (sel < 58) begin
          // position past the active image, when there is room for one
          if (eff_height() < MAX_HEIGHT)
            send_request(OP_FILTER, $urandom_range(eff_height(), 255), c, 0);
          else if (eff_width() < MAX_WIDTH)
            send_request(OP_FILTER, r, $urandom_range(eff_width(), 255), 0);
          else
            send_request(OP_FILTER, r, c, 0);
        end else if (sel < 78) begin
          send_request(OP_WRITE, r, c, $urandom_range(0, 255));
        end else if (sel < 88) begin
          send_request(OP_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255));
        end else if (sel < 93) begin
          send_request(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255));
        end else if (eff_width() * eff_height() <= 64) begin
          send_request(OP_ESTIMATE, $urandom_range(0, 255), $urandom_range(0, 255), 0);
        end else begin
          send_request(OP_FILTER, r, c, 0);
        end
      end
    end
  endtask

  initial begin
    int drain_wait;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_degenerate_settings();
    test_extreme_dimensions();
    test_backpressure();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    drain_wait = 0;
    while (pending_results.size() != 0 && drain_wait < IDLE_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (400) @(posedge clk);

    $display("covered %0d writes, %0d filters, %0d estimates, %0d off-image filters,",
             n_writes, n_filters, n_estimates, n_outside);
    $display("%0d unused opcodes, %0d register writes; %0d results checked",
             n_idle_ops, n_cfg, n_checked);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending_results.size() != 0)
        $error("%0d expected results never arrived", pending_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
